// File: hdl/slu_pkg.sv
package slu_pkg;

  // Width of the line counter held inside the block.
  localparam int LINE_COUNT_WIDTH = 32;
  // Width of the line count reported with every result.
  localparam int LINE_COUNT_OUT_W = 32;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] phase_t;
  typedef logic [LINE_COUNT_WIDTH-1:0] line_cnt_t;

  // Decoder phases.
  localparam phase_t PH_IDLE = 2'd0;
  localparam phase_t PH_BODY = 2'd1;
  localparam phase_t PH_ESC  = 2'd2;
  localparam phase_t PH_CR   = 2'd3;

  // Completion codes.
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_NOTSTR  = 3'd1;
  localparam status_t ST_NEWLINE = 3'd2;
  localparam status_t ST_NUL     = 3'd3;
  localparam status_t ST_BADESC  = 3'd4;

  // Character codes of interest.
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_NUL    = 8'h00;

  // Result of looking up the byte that follows a backslash.
  typedef struct packed {
    logic  known;
    byte_t ch;
  } esc_map_t;

  // Simple one-character escapes; line breaks are handled by the caller.
  function automatic esc_map_t esc_lookup(byte_t c);
    esc_map_t r;
    r.known = 1'b1;
    r.ch    = 8'h00;
    unique case (c)
      8'h6E:   r.ch = 8'h0A; // n
      8'h74:   r.ch = 8'h09; // t
      8'h62:   r.ch = 8'h08; // b
      8'h72:   r.ch = 8'h0D; // r
      8'h66:   r.ch = 8'h0C; // f
      8'h61:   r.ch = 8'h07; // a
      8'h5C:   r.ch = 8'h5C; // backslash
      8'h3F:   r.ch = 8'h3F; // question mark
      8'h27:   r.ch = 8'h27; // single quote
      8'h22:   r.ch = 8'h22; // double quote
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/string_literal_unescaper_core.sv
// Decodes a double-quoted C string literal fed one source byte per transfer
// and returns exactly one result per byte: an optional decoded character,
// a done flag with a completion status, and the escaped-line counter. Each
// byte is decided by a small phase register and one level of decode logic
// in the cycle it is accepted, and the result lands in an output register,
// so the block sustains one byte per clock cycle while the output is not stalled.
// A new byte is taken whenever the output register is empty or its result
// is being taken in the same cycle. The single configuration register
// (line_count_enable, reset 1) is written through the cfg_ port, which is
// always ready.
module string_literal_unescaper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Source bytes
  input  logic                                in_valid,
  output logic                                in_stall,
  input  slu_pkg::byte_t                      in_char,
  // Decoded results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_char_valid,
  output slu_pkg::byte_t                      out_char,
  output logic                                out_done_res,
  output slu_pkg::status_t                    out_status,
  output logic [slu_pkg::LINE_COUNT_OUT_W-1:0] out_line_count,
  // Configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);
  import slu_pkg::*;

  logic       enable_r;
  phase_t     phase_r, phase_nxt;
  line_cnt_t  line_cnt_r, line_cnt_nxt;

  logic       out_valid_r;
  logic       char_valid_r, char_valid_nxt;
  byte_t      char_r, char_nxt;
  logic       done_r, done_nxt;
  status_t    status_r, status_nxt;
  line_cnt_t  line_out_r;

  logic       in_acc;
  logic       bump;
  phase_t     ph_eff;
  esc_map_t   esc;

  // The output register frees up when it is empty or being drained.
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  // Per-byte decode.
  always_comb begin
    phase_nxt      = phase_r;
    char_valid_nxt = 1'b0;
    char_nxt       = 8'h00;
    done_nxt       = 1'b0;
    status_nxt     = ST_OK;
    bump           = 1'b0;
    esc            = esc_lookup(in_char);
    // After an escaped CR any byte other than LF is an ordinary body byte.
    ph_eff         = (phase_r == PH_CR) ? PH_BODY : phase_r;

    if (phase_r == PH_CR && in_char == CH_LF) begin
      // LF completing an escaped CR LF pair: swallowed silently.
      phase_nxt = PH_BODY;
    end else begin
      unique case (ph_eff)
        PH_IDLE: begin
          if (in_char == CH_QUOTE) begin
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt  = PH_IDLE;
            done_nxt   = 1'b1;
            status_nxt = ST_NOTSTR;
          end
        end
        PH_BODY: begin
          priority if (in_char == CH_QUOTE) begin
            done_nxt   = 1'b1;
            status_nxt = ST_OK;
            phase_nxt  = PH_IDLE;
          end else if (in_char == CH_LF) begin
            done_nxt   = 1'b1;
            status_nxt = ST_NEWLINE;
            phase_nxt  = PH_IDLE;
          end else if (in_char == CH_NUL) begin
            done_nxt   = 1'b1;
            status_nxt = ST_NUL;
            phase_nxt  = PH_IDLE;
          end else if (in_char == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            phase_nxt      = PH_BODY;
            char_valid_nxt = 1'b1;
            char_nxt       = in_char;
          end
        end
        default: begin
          // Byte after a backslash.
          priority if (esc.known) begin
            phase_nxt      = PH_BODY;
            char_valid_nxt = 1'b1;
            char_nxt       = esc.ch;
          end else if (in_char == CH_LF) begin
            phase_nxt = PH_BODY;
            bump      = 1'b1;
          end else if (in_char == CH_CR) begin
            phase_nxt = PH_CR;
            bump      = 1'b1;
          end else begin
            phase_nxt  = PH_IDLE;
            done_nxt   = 1'b1;
            status_nxt = ST_BADESC;
          end
        end
      endcase
    end

    line_cnt_nxt = (bump && enable_r) ? line_cnt_r + 1'b1 : line_cnt_r;
  end

  // Decoder state, updated on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      line_cnt_r <= '0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_valid_r <= char_valid_nxt;
      char_r       <= char_nxt;
      done_r       <= done_nxt;
      status_r     <= status_nxt;
      line_out_r   <= line_cnt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = char_valid_r;
  assign out_char       = char_r;
  assign out_done_res   = done_r;
  assign out_status     = status_r;
  assign out_line_count = LINE_COUNT_OUT_W'(line_out_r);

  // A non-ok status only ever comes with the end of a literal.
  a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ST_OK)
    else $error("status set without done");

  // A decoded character never comes with the end of a literal.
  a_char_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(char_valid_r && done_r))
    else $error("character and done together");

  // The line counter moves only on an accepted byte.
  a_cnt_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(line_cnt_r))
    else $error("line counter moved without a transfer");

  // The line counter steps by at most one per byte.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (line_cnt_r == $past(line_cnt_r)) ||
               (line_cnt_r == line_cnt_t'($past(line_cnt_r) + 1'b1)))
    else $error("line counter jumped");

  // The escaped-CR phase is entered only from the escape phase.
  a_cr_from_esc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r == PH_CR) |-> $past(phase_r) == PH_ESC)
    else $error("escaped CR phase entered from the wrong phase");

endmodule
